[hdl/fibonacci_mod_matrix_power_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Fibonacci matrix power block
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_MOD_MATRIX_POWER_MACROS_SVH
`define FIBONACCI_MOD_MATRIX_POWER_MACROS_SVH

`ifndef SYNTHESIS

`define FMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define FMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define FMP_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define FMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/fmp_pkg.sv]
// ----------------------------------------------------------------------------
// Fibonacci matrix power package
// Sequencer states and fixed constants shared by the block files.
// ----------------------------------------------------------------------------
package fmp_pkg;

  localparam int FIB_W = 31;

  localparam logic [31:0] MOD_RESET_VALUE = 32'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_ADD,
    ST_BASE,
    ST_FINISH
  } state_t;

endpackage

[hdl/fmp_if.sv]
// ----------------------------------------------------------------------------
// Fibonacci matrix power channel interfaces
// Valid/ready channels for exponent bits, results and modulus writes.
// ----------------------------------------------------------------------------
interface fmp_in_if;
  logic valid;
  logic ready;
  logic exponent_bit;
  logic last_bit;

  modport source (output valid, exponent_bit, last_bit, input ready);
  modport sink (input valid, exponent_bit, last_bit, output ready);
endinterface

interface fmp_out_if import fmp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [FIB_W-1:0] fib_value;

  modport source (output valid, fib_value, input ready);
  modport sink (input valid, fib_value, output ready);
endinterface

interface fmp_cfg_if #(
  parameter int MOD_WIDTH = 31
);
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] modulus;

  modport source (output valid, modulus, input ready);
  modport sink (input valid, modulus, output ready);
endinterface

[hdl/fibonacci_mod_matrix_power.sv]
// ----------------------------------------------------------------------------
// Fibonacci matrix power modulo a configured modulus
// Bit-serial square-and-multiply of the matrix [[1,1],[1,0]].
// ----------------------------------------------------------------------------
// The exponent arrives on in_chan one bit per word, most significant bit
// first; last_bit marks the least significant bit. For every bit the kept
// matrix is squared modulo the modulus and, for a one bit, multiplied by the
// base matrix. After the last bit out_chan carries entry [0][0], which is
// F(n+1) mod modulus, and the kept matrix returns to identity.
// The modulus is written on cfg_chan, which is always ready; write it only
// while no exponent bit is in progress.
// Each bit runs a serial reduction of the four entries, then eight serial
// shift-add modular multiplies, the add step and, for a one bit, the base
// matrix multiply. in_chan is ready only between bits.
// The result sits in an output register; a stalled receiver holds the block
// only when the next result is ready and the register is still full.
// Reset loads the modulus 1000000007 and the identity matrix, and empties
// the output register.
// ----------------------------------------------------------------------------
`include "fibonacci_mod_matrix_power_macros.svh"

module fibonacci_mod_matrix_power
  import fmp_pkg::*;
#(
  parameter int MOD_WIDTH = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  fmp_in_if.sink     in_chan,
  fmp_out_if.source  out_chan,
  fmp_cfg_if.sink    cfg_chan
);

  localparam int W     = MOD_WIDTH;
  localparam int CNT_W = $clog2(MOD_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_WIDTH - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     mod_r, mod_nxt;
  logic [W-1:0]     mat_r [4];
  logic [W-1:0]     mat_nxt [4];
  logic [W-1:0]     red_r [4];
  logic [W-1:0]     red_nxt [4];
  logic [W-1:0]     acc_r [8];
  logic [W-1:0]     acc_nxt [8];
  logic             bit_r, bit_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [FIB_W-1:0] out_fib_r, out_fib_nxt;
  logic             in_fire;

  function automatic logic [W-1:0] red_step(logic [W-1:0] rem, logic b, logic [W-1:0] m);
    logic [W:0] t;
    logic [W:0] d;
    t = {rem, b};
    d = t - {1'b0, m};
    if (m != '0 && t >= {1'b0, m}) begin
      return d[W-1:0];
    end
    return t[W-1:0];
  endfunction

  function automatic logic [W-1:0] mul_step(logic [W-1:0] acc, logic b, logic [W-1:0] addend,
                                            logic [W-1:0] m);
    logic [W+1:0] t;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    logic [W+1:0] d1;
    logic [W+1:0] d2;
    t  = {1'b0, acc, 1'b0} + (b ? {2'b00, addend} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    d1 = t - m1;
    d2 = t - m2;
    if (m == '0) begin
      return t[W-1:0];
    end else if (t >= m2) begin
      return d2[W-1:0];
    end else if (t >= m1) begin
      return d1[W-1:0];
    end
    return t[W-1:0];
  endfunction

  function automatic logic [W-1:0] add_mod(logic [W-1:0] p, logic [W-1:0] q, logic [W-1:0] m);
    logic [W:0] s;
    logic [W:0] d;
    s = {1'b0, p} + {1'b0, q};
    d = s - {1'b0, m};
    if (m != '0 && s >= {1'b0, m}) begin
      return d[W-1:0];
    end
    return s[W-1:0];
  endfunction

  assign in_chan.ready   = (state_r == ST_IDLE);
  assign in_fire         = in_chan.valid && in_chan.ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.fib_value = out_fib_r;
  assign cfg_chan.ready  = 1'b1;

  always_comb begin
    logic [2:0]           kk;
    logic [1:0]           ai;
    logic [1:0]           bi;
    logic [1:0]           ee;
    logic [FIB_W+W-1:0]   wide;
    kk            = '0;
    ai            = '0;
    bi            = '0;
    ee            = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mat_nxt       = mat_r;
    red_nxt       = red_r;
    acc_nxt       = acc_r;
    bit_nxt       = bit_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_fib_nxt   = out_fib_r;
    mod_nxt       = cfg_chan.valid ? W'(cfg_chan.modulus) : mod_r;
    wide          = {{FIB_W{1'b0}}, mat_r[0]};
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          bit_nxt   = in_chan.exponent_bit;
          last_nxt  = in_chan.last_bit;
          cnt_nxt   = '0;
          for (int e = 0; e < 4; e++) begin
            ee = 2'(e);
            red_nxt[ee] = '0;
          end
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        for (int e = 0; e < 4; e++) begin
          ee = 2'(e);
          red_nxt[ee] = red_step(red_r[ee], mat_r[ee][W-1], mod_r);
          mat_nxt[ee] = {mat_r[ee][W-2:0], mat_r[ee][W-1]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt = '0;
          for (int k = 0; k < 8; k++) begin
            kk = 3'(k);
            acc_nxt[kk] = '0;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // Product k adds x[i][l] * x[l][j] into entry [i][j], k = {i, j, l}.
        for (int k = 0; k < 8; k++) begin
          kk = 3'(k);
          ai = {kk[2], kk[0]};
          bi = {kk[0], kk[1]};
          acc_nxt[kk] = mul_step(acc_r[kk], mat_r[ai][W-1], red_r[bi], mod_r);
        end
        for (int e = 0; e < 4; e++) begin
          ee = 2'(e);
          mat_nxt[ee] = {mat_r[ee][W-2:0], mat_r[ee][W-1]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int e = 0; e < 4; e++) begin
          ee = 2'(e);
          mat_nxt[ee] = add_mod(acc_r[{ee, 1'b0}], acc_r[{ee, 1'b1}], mod_r);
        end
        state_nxt = bit_r ? ST_BASE : ST_FINISH;
      end
      ST_BASE: begin
        mat_nxt[0] = add_mod(mat_r[0], mat_r[1], mod_r);
        mat_nxt[1] = mat_r[0];
        mat_nxt[2] = add_mod(mat_r[2], mat_r[3], mod_r);
        mat_nxt[3] = mat_r[2];
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_fib_nxt   = wide[FIB_W-1:0];
          mat_nxt[0]    = W'(1);
          mat_nxt[1]    = '0;
          mat_nxt[2]    = '0;
          mat_nxt[3]    = W'(1);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_RESET_VALUE[W-1:0];
      mat_r[0]    <= W'(1);
      mat_r[1]    <= '0;
      mat_r[2]    <= '0;
      mat_r[3]    <= W'(1);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mod_r       <= mod_nxt;
      mat_r       <= mat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r     <= red_nxt;
    acc_r     <= acc_nxt;
    bit_r     <= bit_nxt;
    last_r    <= last_nxt;
    out_fib_r <= out_fib_nxt;
  end

  `FMP_ASSERT_NEXT(a_reduce_to_mul, clk, rst_n,
    state_r == ST_REDUCE && cnt_r == CNT_LAST, state_r == ST_MUL)
  `FMP_ASSERT_IMPL(a_result_from_finish, clk, rst_n,
    $rose(out_valid_r), $past(state_r == ST_FINISH && last_r))
  `FMP_ASSERT_NEXT(a_identity_after_result, clk, rst_n,
    state_r == ST_FINISH && last_r && (!out_valid_r || out_chan.ready),
    mat_r[0] == W'(1) && mat_r[1] == '0 && mat_r[2] == '0 && mat_r[3] == W'(1))
  `FMP_ASSERT_IMPL(a_products_reduced, clk, rst_n,
    state_r == ST_ADD && mod_r != '0,
    acc_r[0] < mod_r && acc_r[3] < mod_r && acc_r[4] < mod_r && acc_r[7] < mod_r)

endmodule
